// ===== rtl/log_record_protobuf_field_emitter_top_defines.svh =====
// Assertion macros for the protobuf field emitter.
// No dependencies; included by the top level.
`ifndef LOG_RECORD_PROTOBUF_FIELD_EMITTER_TOP_DEFINES_SVH
`define LOG_RECORD_PROTOBUF_FIELD_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LRPFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define LRPFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lrpfe_pkg.sv =====
// Shared types and constants for the protobuf field emitter.
// No dependencies.
package lrpfe_pkg;

  typedef enum logic [3:0] {
    KIND_LOG_START   = 4'd0,
    KIND_TIME        = 4'd1,
    KIND_TIME_NS     = 4'd2,
    KIND_CONTENT     = 4'd3,
    KIND_TAG_PAIR    = 4'd4,
    KIND_TOPIC       = 4'd5,
    KIND_SOURCE      = 4'd6,
    KIND_MACHINE_ID  = 4'd7,
    KIND_VALUE_OPEN  = 4'd8,
    KIND_DATA        = 4'd9
  } kind_t;

  localparam logic [7:0] TAG_LOG      = 8'h0A;
  localparam logic [7:0] TAG_TIME     = 8'h08;
  localparam logic [7:0] TAG_TIME_NS  = 8'h25;
  localparam logic [7:0] TAG_CONTENT  = 8'h12;
  localparam logic [7:0] TAG_PAIR     = 8'h32;
  localparam logic [7:0] TAG_TOPIC    = 8'h1A;
  localparam logic [7:0] TAG_SOURCE   = 8'h22;
  localparam logic [7:0] TAG_MACHINE  = 8'h2A;
  localparam logic [7:0] TAG_KEY      = 8'h0A;
  localparam logic [7:0] TAG_VALUE    = 8'h12;

  localparam int LEN_W = 28;

  // Config register indexes
  localparam logic REG_MIN_LOG_TIME = 1'b0;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_TAG_VARINT,
    CMD_TAG_RAW4,
    CMD_PAIR
  } cmd_mode_t;

  typedef struct packed {
    cmd_mode_t          mode;
    logic [7:0]         first_byte;
    logic [31:0]        val1;
    logic [LEN_W-1:0]   val2;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VAR1,
    BK_KEYTAG,
    BK_VAR2,
    BK_RAW
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_status_t;

  // Bytes taken by the varint of a 28-bit length: 1 to 4.
  function automatic logic [2:0] varint_size(input logic [LEN_W-1:0] n);
    logic [2:0] s;
    s = 3'd1;
    if (n[LEN_W-1:7] != '0) s = 3'd2;
    if (n[LEN_W-1:14] != '0) s = 3'd3;
    if (n[LEN_W-1:21] != '0) s = 3'd4;
    return s;
  endfunction

endpackage

// ===== rtl/log_record_protobuf_field_emitter_top.sv =====
// Top level of the protobuf field emitter: config register, front, queue, back.
// Depends on lrpfe_pkg, lrpfe_front, lrpfe_queue, lrpfe_back and the defines header.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid/in_stall, kind, word, key_length,   | in
//          | value_length, data_byte                      |
//  output  | out_valid/out_stall, out_byte, last          | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata | APB slave
//
// Wire bytes per command, as the back sequencer emits them:
// data bytes 1, headers 2 to 11. The front takes a word per cycle until the
// QUEUE_DEPTH-entry queue fills, so bursts of headers are absorbed there.
// Reset (rst, synchronous) empties the queue, idles the sequencer, clears the
// stored value length and loads min_log_time with 0x10000000.
// An output stall on a pending byte freezes the output register and the sequencer;
// the front keeps accepting until the queue is full, then raises in_stall.
`include "log_record_protobuf_field_emitter_top_defines.svh"

module log_record_protobuf_field_emitter_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // command words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  kind,
  input  logic [31:0]                 word,
  input  logic [lrpfe_pkg::LEN_W-1:0] key_length,
  input  logic [lrpfe_pkg::LEN_W-1:0] value_length,
  input  logic [7:0]                  data_byte,
  // wire bytes
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        last,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [31:0]             min_log_time;
  logic                    cfg_write;
  logic                    q_push, q_full, q_empty;
  lrpfe_pkg::cmd_t         q_cmd, head_cmd;
  lrpfe_pkg::back_status_t back_status;

  // Single register at byte 0; paddr[2] is the register index.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == lrpfe_pkg::REG_MIN_LOG_TIME) ? min_log_time : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_log_time <= 32'h1000_0000;
    end else if (cfg_write && paddr[2] == lrpfe_pkg::REG_MIN_LOG_TIME) begin
      min_log_time <= pwdata;
    end
  end

  // classify and clamp; pair opens compute the combined string size here
  lrpfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .word         (word),
    .key_length   (key_length),
    .value_length (value_length),
    .data_byte    (data_byte),
    .min_log_time (min_log_time),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  lrpfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (back_status.pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // one wire byte per cycle into the output register, unless out_stall holds a pending byte
  lrpfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .status    (back_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  // front never writes a full queue
  `LRPFE_ASSERT_NOW(a_no_overflow, clk, rst, q_push, !q_full)
  // back never reads an empty queue
  `LRPFE_ASSERT_NOW(a_no_underflow, clk, rst, back_status.pop, !q_empty)
  // a pending non-final byte means the sequencer still holds the rest
  `LRPFE_ASSERT_NOW(a_rest_in_back, clk, rst, out_valid && !last, back_status.busy)
  // a taken non-final byte is followed by another byte
  `LRPFE_ASSERT_NEXT(a_run_continues, clk, rst, out_valid && !last && !out_stall, out_valid)

endmodule

// ===== rtl/lrpfe_front.sv =====
// Front end: accepts field commands, classifies them into queue words.
// Depends on lrpfe_pkg.
module lrpfe_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  kind,
  input  logic [31:0]                 word,
  input  logic [lrpfe_pkg::LEN_W-1:0] key_length,
  input  logic [lrpfe_pkg::LEN_W-1:0] value_length,
  input  logic [7:0]                  data_byte,
  input  logic [31:0]                 min_log_time,
  input  logic                        q_full,
  output logic                        q_push,
  output lrpfe_pkg::cmd_t             q_cmd
);

  logic [lrpfe_pkg::LEN_W-1:0] pending_len, pending_len_next;
  logic                        accept;
  logic                        is_cmd;
  logic [29:0]                 pair_sum;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && is_cmd;

  // S(k) + S(v) = 2 + size(k) + size(v) + k + v, below 2^30
  assign pair_sum = 30'd2
                  + {27'd0, lrpfe_pkg::varint_size(key_length)}
                  + {27'd0, lrpfe_pkg::varint_size(value_length)}
                  + {2'd0, key_length}
                  + {2'd0, value_length};

  always_comb begin
    is_cmd           = 1'b1;
    pending_len_next = pending_len;
    q_cmd.mode       = lrpfe_pkg::CMD_TAG_VARINT;
    q_cmd.first_byte = lrpfe_pkg::TAG_LOG;
    q_cmd.val1       = word;
    q_cmd.val2       = key_length;
    case (lrpfe_pkg::kind_t'(kind))
      lrpfe_pkg::KIND_LOG_START: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_LOG;
      end
      lrpfe_pkg::KIND_TIME: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_TIME;
        q_cmd.val1       = (word < min_log_time) ? min_log_time : word;
      end
      lrpfe_pkg::KIND_TIME_NS: begin
        q_cmd.mode       = lrpfe_pkg::CMD_TAG_RAW4;
        q_cmd.first_byte = lrpfe_pkg::TAG_TIME_NS;
      end
      lrpfe_pkg::KIND_CONTENT, lrpfe_pkg::KIND_TAG_PAIR: begin
        q_cmd.mode       = lrpfe_pkg::CMD_PAIR;
        q_cmd.first_byte = (lrpfe_pkg::kind_t'(kind) == lrpfe_pkg::KIND_CONTENT) ?
                           lrpfe_pkg::TAG_CONTENT : lrpfe_pkg::TAG_PAIR;
        q_cmd.val1       = {2'd0, pair_sum};
        pending_len_next = value_length;
      end
      lrpfe_pkg::KIND_TOPIC: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_TOPIC;
      end
      lrpfe_pkg::KIND_SOURCE: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_SOURCE;
      end
      lrpfe_pkg::KIND_MACHINE_ID: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_MACHINE;
      end
      lrpfe_pkg::KIND_VALUE_OPEN: begin
        q_cmd.first_byte = lrpfe_pkg::TAG_VALUE;
        q_cmd.val1       = {4'd0, pending_len};
      end
      lrpfe_pkg::KIND_DATA: begin
        q_cmd.mode       = lrpfe_pkg::CMD_BYTE;
        q_cmd.first_byte = data_byte;
      end
      default: begin
        // unused kinds: swallowed, nothing emitted
        is_cmd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_len <= '0;
    end else if (accept) begin
      pending_len <= pending_len_next;
    end
  end

endmodule

// ===== rtl/lrpfe_queue.sv =====
// Short command queue between front and back.
// Depends on lrpfe_pkg.
module lrpfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrpfe_pkg::cmd_t push_cmd,
  input  logic            pop,
  output lrpfe_pkg::cmd_t head_cmd,
  output logic            empty,
  output logic            full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  lrpfe_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lrpfe_back.sv =====
// Back end: byte sequencer that turns queue words into wire bytes.
// Depends on lrpfe_pkg.
module lrpfe_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lrpfe_pkg::cmd_t          head_cmd,
  input  logic                     q_empty,
  output lrpfe_pkg::back_status_t  status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_byte,
  output logic                     last
);

  lrpfe_pkg::back_state_t      state, state_next;
  logic [31:0]                 shift, shift_next;
  logic [lrpfe_pkg::LEN_W-1:0] key_len, key_len_next;
  logic                        pair, pair_next;
  logic [1:0]                  cnt, cnt_next;
  logic                        load, emit, pop;
  logic [7:0]                  emit_byte;
  logic                        emit_last;
  logic                        var_done;

  assign load     = !out_valid || !out_stall;
  assign pop      = load && (state == lrpfe_pkg::BK_IDLE) && !q_empty;
  assign emit     = load && ((state != lrpfe_pkg::BK_IDLE) || !q_empty);
  assign var_done = (shift[31:7] == '0);

  assign status.busy = (state != lrpfe_pkg::BK_IDLE);
  assign status.pop  = pop;

  // next state
  always_comb begin
    state_next = state;
    if (load) begin
      case (state)
        lrpfe_pkg::BK_IDLE: begin
          if (!q_empty) begin
            case (head_cmd.mode)
              lrpfe_pkg::CMD_BYTE:     state_next = lrpfe_pkg::BK_IDLE;
              lrpfe_pkg::CMD_TAG_RAW4: state_next = lrpfe_pkg::BK_RAW;
              default:                 state_next = lrpfe_pkg::BK_VAR1;
            endcase
          end
        end
        lrpfe_pkg::BK_VAR1: begin
          if (var_done) begin
            state_next = pair ? lrpfe_pkg::BK_KEYTAG : lrpfe_pkg::BK_IDLE;
          end
        end
        lrpfe_pkg::BK_KEYTAG: state_next = lrpfe_pkg::BK_VAR2;
        lrpfe_pkg::BK_VAR2: begin
          if (var_done) state_next = lrpfe_pkg::BK_IDLE;
        end
        lrpfe_pkg::BK_RAW: begin
          if (cnt == 2'd3) state_next = lrpfe_pkg::BK_IDLE;
        end
        default: state_next = lrpfe_pkg::BK_IDLE;
      endcase
    end
  end

  // byte and last flag
  always_comb begin
    emit_byte = head_cmd.first_byte;
    emit_last = 1'b0;
    case (state)
      lrpfe_pkg::BK_IDLE: begin
        emit_byte = head_cmd.first_byte;
        emit_last = (head_cmd.mode == lrpfe_pkg::CMD_BYTE);
      end
      lrpfe_pkg::BK_VAR1: begin
        emit_byte = {!var_done, shift[6:0]};
        emit_last = var_done && !pair;
      end
      lrpfe_pkg::BK_KEYTAG: begin
        emit_byte = lrpfe_pkg::TAG_KEY;
      end
      lrpfe_pkg::BK_VAR2: begin
        emit_byte = {!var_done, shift[6:0]};
        emit_last = var_done;
      end
      lrpfe_pkg::BK_RAW: begin
        emit_byte = shift[7:0];
        emit_last = (cnt == 2'd3);
      end
      default: begin
        emit_byte = head_cmd.first_byte;
        emit_last = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    shift_next   = shift;
    key_len_next = key_len;
    pair_next    = pair;
    cnt_next     = cnt;
    if (load) begin
      case (state)
        lrpfe_pkg::BK_IDLE: begin
          if (!q_empty) begin
            shift_next   = head_cmd.val1;
            key_len_next = head_cmd.val2;
            pair_next    = (head_cmd.mode == lrpfe_pkg::CMD_PAIR);
            cnt_next     = 2'd0;
          end
        end
        lrpfe_pkg::BK_VAR1, lrpfe_pkg::BK_VAR2: shift_next = {7'd0, shift[31:7]};
        lrpfe_pkg::BK_KEYTAG: shift_next = {4'd0, key_len};
        lrpfe_pkg::BK_RAW: begin
          shift_next = {8'd0, shift[31:8]};
          cnt_next   = cnt + 2'd1;
        end
        default: shift_next = shift;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrpfe_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift   <= shift_next;
    key_len <= key_len_next;
    pair    <= pair_next;
    cnt     <= cnt_next;
    if (load && emit) begin
      out_byte <= emit_byte;
      last     <= emit_last;
    end
  end

endmodule

// ===== verif/log_record_protobuf_field_emitter_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for log_record_protobuf_field_emitter_top: drives command words, predicts wire
// bytes with its own protobuf encoder and checks every output word in order. Needs lrpfe_pkg.

module log_record_protobuf_field_emitter_top_tb;
  import lrpfe_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          QUIET_CYCLES = 80;   // sized to the queue depth and the longest header, with margin
  localparam int          HOLD_CYCLES  = 200;
  localparam int          REPORT_MAX   = 10;
  localparam logic [2:0]  ADDR_MIN_LOG_TIME = {REG_MIN_LOG_TIME, 2'b00};
  localparam logic [31:0] MIN_LOG_TIME_RESET = 32'h1000_0000;
  localparam logic [3:0]  KIND_UNUSED_LO = 4'd10;
  localparam logic [3:0]  KIND_UNUSED_HI = 4'd15;

  // Expected wire bytes: encoder state plus the queue of bytes still owed.
  class wire_byte_scoreboard;
    logic [31:0]      min_log_time;
    logic [LEN_W-1:0] stored_value_len;
    logic [8:0]       owed_bytes[$];   // {last, byte}
    int               mismatches;
    int               bytes_checked;
    int               commands_taken;

    function new();
      min_log_time     = MIN_LOG_TIME_RESET;
      stored_value_len = '0;
      mismatches       = 0;
      bytes_checked    = 0;
      commands_taken   = 0;
    endfunction

    // Append one entry at the tail of the owed queue.
    function void owe_word(logic [8:0] w);
      owed_bytes = {owed_bytes, w};
    endfunction

    function void push_byte(logic [7:0] b);
      owe_word({1'b0, b});
    endfunction

    function void push_varint(logic [31:0] v);
      while (v >= 32'h80) begin
        push_byte({1'b1, v[6:0]});
        v = v >> 7;
      end
      push_byte(v[7:0]);
    endfunction

    function logic [31:0] varint_len(logic [31:0] v);
      if (v < 32'h80)        return 1;
      if (v < 32'h4000)      return 2;
      if (v < 32'h20_0000)   return 3;
      if (v < 32'h1000_0000) return 4;
      return 5;
    endfunction

    // Key or value string field: tag, length varint, body.
    function logic [31:0] string_field_len(logic [LEN_W-1:0] n);
      return 32'd1 + varint_len(32'(n)) + 32'(n);
    endfunction

    function void take_command(logic [3:0] kind, logic [31:0] w, logic [LEN_W-1:0] klen,
                               logic [LEN_W-1:0] vlen, logic [7:0] dbyte);
      int         owed_before;
      logic [8:0] tail;
      logic [31:0] t;
      owed_before = owed_bytes.size();
      case (kind)
        KIND_LOG_START: begin
          push_byte(TAG_LOG);
          push_varint(w);
        end
        KIND_TIME: begin
          t = (w < min_log_time) ? min_log_time : w;
          push_byte(TAG_TIME);
          push_varint(t);
        end
        KIND_TIME_NS: begin
          push_byte(TAG_TIME_NS);
          push_byte(w[7:0]);
          push_byte(w[15:8]);
          push_byte(w[23:16]);
          push_byte(w[31:24]);
        end
        KIND_CONTENT, KIND_TAG_PAIR: begin
          push_byte(kind == KIND_CONTENT ? TAG_CONTENT : TAG_PAIR);
          push_varint(string_field_len(klen) + string_field_len(vlen));
          push_byte(TAG_KEY);
          push_varint(32'(klen));
          stored_value_len = vlen;
        end
        KIND_TOPIC:      begin push_byte(TAG_TOPIC);   push_varint(w); end
        KIND_SOURCE:     begin push_byte(TAG_SOURCE);  push_varint(w); end
        KIND_MACHINE_ID: begin push_byte(TAG_MACHINE); push_varint(w); end
        KIND_VALUE_OPEN: begin
          push_byte(TAG_VALUE);
          push_varint(32'(stored_value_len));
        end
        KIND_DATA:       push_byte(dbyte);
        default: ;
      endcase
      if (owed_bytes.size() > owed_before) begin
        commands_taken++;
        tail = owed_bytes.pop_back();
        tail[8] = 1'b1;
        owe_word(tail);
      end
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      logic [8:0] want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: out_byte %h last %b with nothing owed", b, l);
        return;
      end
      want = owed_bytes.pop_front();
      if (b !== want[7:0]) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("out_byte mismatch at word %0d: expected %h got %h",
                   bytes_checked, want[7:0], b);
      end
      if (l !== want[8]) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("last mismatch at word %0d: expected %b got %b",
                   bytes_checked, want[8], l);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [3:0]       kind = '0;
  logic [31:0]      word = '0;
  logic [LEN_W-1:0] key_length = '0;
  logic [LEN_W-1:0] value_length = '0;
  logic [7:0]       data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             last;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  wire_byte_scoreboard board = new();

  // Idle/stall knobs, in percent; set per phase by the main sequence.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Long output hold: the main sequence bumps hold_requests, the stall process serves it.
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  log_record_protobuf_field_emitter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .word(word), .key_length(key_length),
    .value_length(value_length), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Watchdog: a hung handshake or a lost byte ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed",
               cycle_count, board.owed_bytes.size());
      $display("log_record_protobuf_field_emitter_top_tb: done, errors");
      $finish;
    end
  end

  // Receiver side: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Output monitor: values read here are the ones before this edge's updates.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_byte(out_byte, last);
  end

  // One command word: optional idle gap, then hold it until accepted.
  task automatic send_command(logic [3:0] k, logic [31:0] w, logic [LEN_W-1:0] klen,
                              logic [LEN_W-1:0] vlen, logic [7:0] dbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    word         <= w;
    key_length   <= klen;
    value_length <= vlen;
    data_byte    <= dbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_command(k, w, klen, vlen, dbyte);
  endtask

  // Header command with junk in the fields it ignores.
  task automatic send_header(logic [3:0] k, logic [31:0] w);
    send_command(k, w, LEN_W'($urandom()), LEN_W'($urandom()), 8'($urandom()));
  endtask

  task automatic send_pair(logic [3:0] k, logic [LEN_W-1:0] klen, logic [LEN_W-1:0] vlen);
    send_command(k, $urandom(), klen, vlen, 8'($urandom()));
  endtask

  task automatic send_data();
    send_command(KIND_DATA, $urandom(), LEN_W'($urandom()), LEN_W'($urandom()),
                 8'($urandom_range(255)));
  endtask

  // Values spread over every varint size.
  function automatic logic [31:0] spread_word();
    case ($urandom_range(4))
      0: return $urandom_range(32'h7F);
      1: return $urandom_range(32'h3FFF, 32'h80);
      2: return $urandom_range(32'h1F_FFFF, 32'h4000);
      3: return $urandom_range(32'h0FFF_FFFF, 32'h20_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] spread_len();
    logic [31:0] v;
    v = spread_word();
    return v[LEN_W-1:0];
  endfunction

  // Well-formed record: header fields, then pairs with value bodies.
  task automatic send_log_record();
    int pairs;
    int n;
    send_header(KIND_LOG_START, spread_word());
    send_header(KIND_TIME, ($urandom_range(1)) ? $urandom_range(32'h0FFF_FFFF) : $urandom());
    if ($urandom_range(1)) send_header(KIND_TIME_NS, $urandom());
    if ($urandom_range(2) == 0) send_header(KIND_TOPIC, spread_word());
    if ($urandom_range(2) == 0) send_header(KIND_SOURCE, spread_word());
    if ($urandom_range(2) == 0) send_header(KIND_MACHINE_ID, spread_word());
    pairs = int'($urandom_range(3, 1));
    for (int p = 0; p < pairs; p++) begin
      send_pair($urandom_range(1) ? KIND_CONTENT : KIND_TAG_PAIR, spread_len(), spread_len());
      n = int'($urandom_range(3));
      for (int i = 0; i < n; i++) send_data();
      send_header(KIND_VALUE_OPEN, $urandom());
      n = int'($urandom_range(4));
      for (int i = 0; i < n; i++) send_data();
    end
  endtask

  // Anything at all, unused kinds and out-of-order opens included.
  task automatic send_noise();
    send_command(4'($urandom_range(15)), $urandom(), LEN_W'($urandom()),
                 LEN_W'($urandom()), 8'($urandom()));
  endtask

  task automatic run_random(int count);
    int target;
    target = board.commands_taken + count;
    while (board.commands_taken < target) begin
      if ($urandom_range(99) < 80) send_log_record();
      else send_noise();
    end
  endtask

  // Stop offering, wait for every owed byte, then turn random receiver stalls off and wait QUIET_CYCLES.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (board.owed_bytes.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Setup then access; the write lands at the edge with penable and pready high.
  task automatic write_min_log_time(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MIN_LOG_TIME;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.min_log_time = value;
  endtask

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, varint size edges, every kind, reset clamp value.
    send_header(KIND_VALUE_OPEN, 32'hFFFF_FFFF);         // no pair yet: stored length is zero
    send_header(KIND_LOG_START, 32'h0);
    send_header(KIND_LOG_START, 32'h7F);
    send_header(KIND_LOG_START, 32'h80);
    send_header(KIND_LOG_START, 32'hFFFF_FFFF);
    send_header(KIND_TIME, 32'h0);                       // clamped up
    send_header(KIND_TIME, MIN_LOG_TIME_RESET);
    send_header(KIND_TIME, 32'hFFFF_FFFF);
    send_header(KIND_TIME_NS, 32'h0);
    send_header(KIND_TIME_NS, 32'hFFFF_FFFF);
    send_header(KIND_TIME_NS, 32'h1234_5678);
    send_pair(KIND_CONTENT, '0, '0);
    send_header(KIND_VALUE_OPEN, 32'h0);
    send_pair(KIND_TAG_PAIR, '1, '1);                    // widest header, eleven bytes
    send_header(KIND_VALUE_OPEN, 32'h0);
    send_header(KIND_VALUE_OPEN, 32'h0);                 // stored length survives an open
    send_pair(KIND_CONTENT, 28'h7F, 28'h80);
    send_header(KIND_VALUE_OPEN, 32'h0);
    send_header(KIND_TOPIC, 32'h0);
    send_header(KIND_SOURCE, 32'h3FFF);
    send_header(KIND_MACHINE_ID, 32'h20_0000);
    send_command(KIND_DATA, '1, '1, '1, 8'h00);
    send_command(KIND_DATA, '0, '0, '0, 8'hFF);
    send_command(KIND_UNUSED_LO, '1, '1, '1, 8'hFF);     // unused kinds emit nothing
    send_command(KIND_UNUSED_HI, '1, '1, '1, 8'hFF);
    drain_and_settle();

    // Clamp off; sender mostly idle.
    write_min_log_time(32'h0);
    send_idle_pct = 79;
    recv_stall_pct = 0;
    run_random(120);
    drain_and_settle();

    // Clamp at the top; long hold first so the queue fills and in_stall rises.
    write_min_log_time(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    hold_requests <= hold_requests + 1;
    run_random(120);
    drain_and_settle();

    // Random clamp; both sides idle now and then.
    write_min_log_time($urandom());
    send_idle_pct = 15;
    recv_stall_pct = 15;
    run_random(130);
    drain_and_settle();

    // Back to the reset clamp; full rate.
    write_min_log_time(MIN_LOG_TIME_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(130);
    drain_and_settle();

    $display("covered %0d commands and %0d wire words over five clamp settings,",
             board.commands_taken, board.bytes_checked);
    $display("with idle and stall mixes and a %0d-cycle output hold; %0d mismatches",
             HOLD_CYCLES, board.mismatches);
    if (board.mismatches == 0 && board.owed_bytes.size() == 0)
      $display("log_record_protobuf_field_emitter_top_tb: done, clean");
    else
      $display("log_record_protobuf_field_emitter_top_tb: done, errors");
    $finish;
  end

endmodule
